// ===== sv/tsse_pkg.sv =====
// ----------------------------------------------------------------------------
// tsse_pkg
// Shared types and codes for the three-stack sort engine: request and
// response beats, the decoded operation queued between front and back, and
// the back-end state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package tsse_pkg;

   // Request action codes
   localparam logic [2:0] ACT_LOAD      = 3'd0;
   localparam logic [2:0] ACT_TRANSFER  = 3'd1;
   localparam logic [2:0] ACT_SEARCH    = 3'd2;
   localparam logic [2:0] ACT_PARTITION = 3'd3;
   localparam logic [2:0] ACT_POP       = 3'd4;

   // Stack selectors
   localparam logic [1:0] TUBE_ONE   = 2'd0;
   localparam logic [1:0] TUBE_TWO   = 2'd1;
   localparam logic [1:0] TUBE_THREE = 2'd2;

   // Response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_DROPPED = 2'd2;

   typedef struct packed {
      logic [2:0] action;
      logic [1:0] tube;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] data;
      logic [1:0] status;
      logic [7:0] dropped;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_PUSH,
      OP_POP,
      OP_POP_BAD,
      OP_TRANSFER,
      OP_SEARCH,
      OP_PARTITION
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] tube;
      logic [7:0] value;
   } q_entry_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_port_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_WALK
   } back_state_type;

endpackage

`default_nettype wire

// ===== sv/tsse_ram.sv =====
// ----------------------------------------------------------------------------
// tsse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/tsse_front.sv =====
// ----------------------------------------------------------------------------
// tsse_front
// Request intake: decode each beat into a queued operation and hold it in
// a two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tsse_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire tsse_pkg::req_type    req_item,
   output      tsse_pkg::q_port_type q_port,
   input  wire logic                 q_pop
);
   import tsse_pkg::*;

   localparam int QD = 2;
   localparam int PW = $clog2(QD);
   localparam int FW = $clog2(QD + 1);

   q_entry_type   q_ff [QD];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0] fill_ff, fill_in;
   q_entry_type   entry;
   logic          accept;

   // Classify the request
   always_comb begin
      entry.tube  = req_item.tube;
      entry.value = req_item.value;
      case (req_item.action)
         ACT_LOAD: begin
            if (req_item.tube inside {TUBE_ONE, TUBE_TWO, TUBE_THREE}) begin
               entry.op = OP_PUSH;
            end else begin
               entry.op = OP_NOP;
            end
         end
         ACT_POP: begin
            if (req_item.tube inside {TUBE_ONE, TUBE_TWO, TUBE_THREE}) begin
               entry.op = OP_POP;
            end else begin
               entry.op = OP_POP_BAD;
            end
         end
         ACT_TRANSFER:  entry.op = OP_TRANSFER;
         ACT_SEARCH:    entry.op = OP_SEARCH;
         ACT_PARTITION: entry.op = OP_PARTITION;
         default:       entry.op = OP_NOP;
      endcase
   end

   assign busy         = (fill_ff == FW'(QD));
   assign accept       = start && !busy;
   assign q_port.valid = (fill_ff != '0);
   assign q_port.entry = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({accept, q_pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

// ===== sv/tsse_back.sv =====
// ----------------------------------------------------------------------------
// tsse_back
// Execution engine: owns the three stack RAMs and their counts, runs one
// queued operation at a time and drives the response beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tsse_back #(
   parameter int DEPTH      = 128,
   parameter int VALUE_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tsse_pkg::q_port_type q_port,
   output      logic                 q_pop,
   output      logic                 rsp_strobe,
   output      tsse_pkg::rsp_type    rsp_item
);
   import tsse_pkg::*;

   localparam int SW = (VALUE_BITS < 8) ? VALUE_BITS : 8;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   back_state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff [3];
   logic [CW-1:0]  cnt_in [3];
   logic [CW-1:0]  idx_ff, idx_in;
   logic           pend_ff, pend_in;
   logic           found_ff, found_in;
   logic [7:0]     drop_ff, drop_in;
   op_type         op_ff, op_in;
   logic [1:0]     tube_ff, tube_in;
   logic [SW-1:0]  val_ff, val_in;
   rsp_type        rsp_ff, rsp_in;
   logic           strobe_ff, strobe_in;

   logic          we    [3];
   logic [AW-1:0] waddr [3];
   logic [SW-1:0] wdata [3];
   logic          re    [3];
   logic [AW-1:0] raddr [3];
   logic [SW-1:0] rdata [3];

   for (genvar g = 0; g < 3; g++) begin : g_stack
      tsse_ram #(
         .WIDTH (SW),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (we[g]),
         .wr_addr (waddr[g]),
         .wr_data (wdata[g]),
         .rd_en   (re[g]),
         .rd_addr (raddr[g]),
         .rd_data (rdata[g])
      );
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   always_comb begin
      logic [1:0]    t;
      logic [1:0]    dst;
      logic [SW-1:0] elem;
      logic [CW-1:0] cnt_m1;
      logic [CW-1:0] idx_m1;

      state_in  = state_ff;
      idx_in    = idx_ff;
      pend_in   = pend_ff;
      found_in  = found_ff;
      drop_in   = drop_ff;
      op_in     = op_ff;
      tube_in   = tube_ff;
      val_in    = val_ff;
      rsp_in    = '0;
      strobe_in = 1'b0;
      q_pop     = 1'b0;
      for (int i = 0; i < 3; i++) begin
         cnt_in[i] = cnt_ff[i];
         we[i]     = 1'b0;
         waddr[i]  = '0;
         wdata[i]  = '0;
         re[i]     = 1'b0;
         raddr[i]  = '0;
      end
      t      = q_port.entry.tube;
      cnt_m1 = cnt_ff[t] - 1'b1;
      idx_m1 = idx_ff - 1'b1;
      elem   = rdata[0];
      dst    = TUBE_TWO;

      case (state_ff)
         BK_IDLE: begin
            if (q_port.valid) begin
               q_pop = 1'b1;
               case (q_port.entry.op)
                  OP_PUSH: begin
                     strobe_in = 1'b1;
                     if (cnt_ff[t] < FULL) begin
                        we[t]     = 1'b1;
                        waddr[t]  = cnt_ff[t][AW-1:0];
                        wdata[t]  = SW'(q_port.entry.value);
                        cnt_in[t] = cnt_ff[t] + 1'b1;
                     end else begin
                        rsp_in.status  = ST_DROPPED;
                        rsp_in.dropped = 8'd1;
                     end
                  end
                  OP_POP: begin
                     if (cnt_ff[t] == '0) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        re[t]     = 1'b1;
                        raddr[t]  = cnt_m1[AW-1:0];
                        cnt_in[t] = cnt_m1;
                        tube_in   = t;
                        state_in  = BK_READ;
                     end
                  end
                  OP_POP_BAD: begin
                     strobe_in     = 1'b1;
                     rsp_in.status = ST_EMPTY;
                  end
                  OP_TRANSFER, OP_SEARCH, OP_PARTITION: begin
                     op_in    = q_port.entry.op;
                     val_in   = SW'(q_port.entry.value);
                     idx_in   = cnt_ff[0];
                     pend_in  = 1'b0;
                     found_in = 1'b0;
                     drop_in  = '0;
                     state_in = BK_WALK;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end

         BK_READ: begin
            strobe_in   = 1'b1;
            rsp_in.data = 8'(rdata[tube_ff]);
            state_in    = BK_IDLE;
         end

         BK_WALK: begin
            // Issue: read stack one from the top down
            if (idx_ff != '0) begin
               re[0]    = 1'b1;
               raddr[0] = idx_m1[AW-1:0];
               idx_in   = idx_m1;
               pend_in  = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            // Consume: act on the element read last cycle
            if (pend_ff) begin
               case (op_ff)
                  OP_SEARCH: begin
                     if (elem == val_ff) begin
                        found_in = 1'b1;
                     end
                  end
                  default: begin
                     if (op_ff == OP_PARTITION && elem != val_ff) begin
                        dst = TUBE_THREE;
                     end
                     if (cnt_ff[dst] < FULL) begin
                        we[dst]     = 1'b1;
                        waddr[dst]  = cnt_ff[dst][AW-1:0];
                        wdata[dst]  = elem;
                        cnt_in[dst] = cnt_ff[dst] + 1'b1;
                     end else if (drop_ff != 8'hFF) begin
                        drop_in = drop_ff + 1'b1;
                     end
                  end
               endcase
            end
            if (idx_ff == '0 && !pend_ff) begin
               strobe_in      = 1'b1;
               rsp_in.found   = found_ff;
               rsp_in.dropped = drop_ff;
               rsp_in.status  = (drop_ff != '0) ? ST_DROPPED : ST_OK;
               if (op_ff != OP_SEARCH) begin
                  cnt_in[0] = '0;
               end
               state_in = BK_IDLE;
            end
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         strobe_ff <= 1'b0;
         pend_ff   <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         pend_ff   <= pend_in;
         for (int i = 0; i < 3; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      found_ff <= found_in;
      drop_ff  <= drop_in;
      op_ff    <= op_in;
      tube_ff  <= tube_in;
      val_ff   <= val_in;
      rsp_ff   <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== sv/three_stack_sort_engine.sv =====
// ----------------------------------------------------------------------------
// three_stack_sort_engine
// Three bounded stacks of color values with load, transfer, search,
// partition and pop commands; one response beat per command.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; busy rises only
// when the two-entry command queue is full. Every command gives exactly one
// response beat, in command order, shown for a single cycle with rsp_strobe
// high; the receiver cannot stall it, so sample it on that cycle. An idle back
// end picks a command from the queue in the cycle right after its beat is
// taken, and the response shows in the cycle after the last execution cycle.
// Load and no-op commands need no RAM read; a pop that finds data waits on the
// registered stack RAM read. Transfer, search and partition walk stack one
// one element per cycle through its single read port, and this walk sets the
// worst-case time per command. While the back end runs, the queue keeps
// taking up to two more command beats. Stack RAMs are not cleared at reset;
// only the counts are.
// ----------------------------------------------------------------------------
`default_nettype none

module three_stack_sort_engine #(
   parameter int DEPTH      = 128,
   parameter int VALUE_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output      logic              busy,
   input  wire tsse_pkg::req_type req_item,
   output      logic              rsp_strobe,
   output      tsse_pkg::rsp_type rsp_item
);
   import tsse_pkg::*;

   // Decoded command handed from the front to the back
   q_port_type q_port;
   logic       q_pop;

   // Front: classify commands and hold them in the queue
   tsse_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_port   (q_port),
      .q_pop    (q_pop)
   );

   // Back: run commands against the stacks, produce the response beat
   tsse_back #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_port     (q_port),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

// ===== sv/tsse_checker.sv =====
// ----------------------------------------------------------------------------
// tsse_checker
// Port-level checks on the response beat of the three-stack sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tsse_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire tsse_pkg::req_type req_item,
   input wire logic              rsp_strobe,
   input wire tsse_pkg::rsp_type rsp_item
);
   import tsse_pkg::*;

   logic unused_req;
   assign unused_req = start ^ (^req_item);

   // Come out of reset idle with the queue open
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe && !busy)
      else $error("response or busy right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.status == ST_OK || rsp_item.status == ST_EMPTY
                     || rsp_item.status == ST_DROPPED)
      else $error("undefined status code");

   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status == ST_EMPTY |->
         rsp_item.data == '0 && rsp_item.dropped == '0 && !rsp_item.found)
      else $error("empty pop carries data");

   a_drop_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.dropped != '0) == (rsp_item.status == ST_DROPPED))
      else $error("drop count and status disagree");

   a_found_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.found |-> rsp_item.data == '0)
      else $error("search response carries data");

endmodule

bind three_stack_sort_engine tsse_checker u_tsse_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

`default_nettype wire

// ===== sim/three_stack_sort_engine_tb.sv =====
// ----------------------------------------------------------------------------
// three_stack_sort_engine_tb
// Self-checking bench for the three-stack sort engine. A short directed list
// covers empty pops, the unused tube selector and the unused action codes, and
// hits and misses in search, partition and transfer. A random list follows,
// built mostly from load bursts, walks and pop bursts drawn from a small color
// palette, plus a few fill-to-overflow sequences. A shadow copy of the three
// stacks predicts every response beat, and each beat is checked field by field
// in command order.
// ----------------------------------------------------------------------------
module three_stack_sort_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tsse_pkg::*;

   localparam int DEPTH         = 128;
   localparam int VALUE_BITS    = 8;
   localparam int CLK_HALF      = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int MAX_PAUSE     = 13;
   localparam int RANDOM_ITEMS  = 925;
   localparam int DRAIN_EVERY   = 300;
   localparam int MAX_FILLS     = 3;
   // leave margin for the longest walk and its response
   localparam int SETTLE_CYCLES = DEPTH + 16;
   localparam int STALL_LIMIT   = 4000;
   localparam int MAX_REPORTS   = 40;

   localparam logic [7:0] VALUE_MASK = 8'((2 ** VALUE_BITS) - 1);

   // selector and action codes with no function in the block
   localparam logic [1:0] TUBE_NONE    = 2'd3;
   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   typedef struct {
      req_type cmd;
      int      pause;
      bit      drain_first;
   } cmd_slot_type;

   // -------------------------------------------------------------------------
   // DUT and its signals; every input is known from time zero
   // -------------------------------------------------------------------------
   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   three_stack_sort_engine #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #(CLK_HALF) clock = ~clock;

   // -------------------------------------------------------------------------
   // Shadow stacks: predicted contents and fill levels of the three tubes
   // -------------------------------------------------------------------------
   logic [7:0] shadow_mem  [3][DEPTH];
   int         shadow_fill [3] = '{0, 0, 0};

   cmd_slot_type cmd_backlog [$];   // commands waiting to be driven
   rsp_type      rsp_due     [$];   // predicted responses, oldest first

   int errors        = 0;
   int rsp_checked   = 0;
   int cmds_taken    = 0;
   int search_hits   = 0;
   int empty_pops    = 0;
   int drop_cmds     = 0;
   int peak_fill     = 0;
   int pause_left    = 0;
   int stall_cycles  = 0;

   // stimulus build state
   int         calm_left  = 0;
   int         useful_cnt = 0;
   bit         want_drain = 1'b0;
   logic [7:0] palette [4];

   // Push one color onto a shadow tube; report whether it fit.
   function automatic bit shadow_push(logic [1:0] idx, logic [7:0] v);
      if (shadow_fill[idx] >= DEPTH) return 1'b0;
      shadow_mem[idx][shadow_fill[idx]] = v;
      shadow_fill[idx]++;
      if (shadow_fill[idx] > peak_fill) peak_fill = shadow_fill[idx];
      return 1'b1;
   endfunction

   // Apply one command to the shadow stacks and return the response it gives.
   function automatic rsp_type sort_engine_outcome(req_type c);
      rsp_type    r;
      logic [7:0] v;
      logic [7:0] e;
      int         lost;
      r    = '0;
      lost = 0;
      v    = c.value & VALUE_MASK;
      case (c.action)
         ACT_LOAD: begin
            // the unused selector swallows the load without a flag
            if (c.tube != TUBE_NONE && !shadow_push(c.tube, v)) lost++;
         end
         ACT_TRANSFER: begin
            // stack one always empties, even when stack two overflows
            while (shadow_fill[TUBE_ONE] > 0) begin
               shadow_fill[TUBE_ONE]--;
               e = shadow_mem[TUBE_ONE][shadow_fill[TUBE_ONE]];
               if (!shadow_push(TUBE_TWO, e)) lost++;
            end
         end
         ACT_SEARCH: begin
            for (int i = 0; i < shadow_fill[TUBE_ONE]; i++)
               if (shadow_mem[TUBE_ONE][i] == v) r.found = 1'b1;
            if (r.found) search_hits++;
         end
         ACT_PARTITION: begin
            while (shadow_fill[TUBE_ONE] > 0) begin
               shadow_fill[TUBE_ONE]--;
               e = shadow_mem[TUBE_ONE][shadow_fill[TUBE_ONE]];
               if (!shadow_push((e == v) ? TUBE_TWO : TUBE_THREE, e)) lost++;
            end
         end
         ACT_POP: begin
            if (c.tube != TUBE_NONE && shadow_fill[c.tube] > 0) begin
               shadow_fill[c.tube]--;
               r.data = shadow_mem[c.tube][shadow_fill[c.tube]];
            end else begin
               r.status = ST_EMPTY;
               empty_pops++;
            end
         end
         default: ;
      endcase
      if (lost != 0) begin
         r.status  = ST_DROPPED;
         r.dropped = (lost > 255) ? 8'hFF : 8'(lost);
         drop_cmds++;
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   // Append a command; draw its idle gap, with stretches of back-to-back beats.
   task automatic queue_cmd(logic [2:0] act, logic [1:0] tb, logic [7:0] val);
      cmd_slot_type s;
      s.cmd.action  = act;
      s.cmd.tube    = tb;
      s.cmd.value   = val;
      s.drain_first = want_drain;
      want_drain    = 1'b0;
      if (calm_left > 0) begin
         s.pause = 0;
         calm_left--;
      end else if ($urandom_range(9, 0) == 0) begin
         s.pause   = 0;
         calm_left = $urandom_range(30, 5);
      end else begin
         s.pause = $urandom_range(MAX_PAUSE, 0);
      end
      cmd_backlog.push_back(s);
      // every command counts toward the random budget
      useful_cnt++;
   endtask

   // Mostly a palette color, so searches and partitions find matches.
   function automatic logic [7:0] pick_color();
      if ($urandom_range(4, 0) != 0) return palette[$urandom_range(3, 0)];
      return 8'($urandom_range(255, 0));
   endfunction

   function automatic logic [1:0] any_tube();
      return 2'($urandom_range(3, 0));
   endfunction

   function automatic logic [1:0] real_tube();
      return ($urandom_range(9, 0) == 0) ? TUBE_NONE : 2'($urandom_range(2, 0));
   endfunction

   task automatic refresh_palette();
      for (int k = 0; k < 4; k++) palette[k] = 8'($urandom_range(255, 0));
      // pull the extremes in now and then
      if ($urandom_range(3, 0) == 0) palette[0] = 8'h00;
      if ($urandom_range(3, 0) == 0) palette[1] = 8'hFF;
   endtask

   // -------------------------------------------------------------------------
   // Driver: present backlog commands, predict each beat as it is taken
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      logic    accepted;
      logic    start_n;
      req_type item_n;
      if (reset) begin
         start      <= 1'b0;
         req_item   <= '0;
         pause_left <= 0;
      end else begin
         accepted = start && !busy;
         start_n  = start && !accepted;
         item_n   = req_item;
         if (accepted) begin
            rsp_due.push_back(sort_engine_outcome(req_item));
            cmds_taken++;
         end
         // hold the current beat while busy; otherwise idle or advance
         if (!start_n) begin
            if (pause_left > 0) begin
               pause_left <= pause_left - 1;
            end else if (cmd_backlog.size() != 0) begin
               if (cmd_backlog[0].pause > 0) begin
                  pause_left <= cmd_backlog[0].pause - 1;
                  cmd_backlog[0].pause = 0;
               end else if (!cmd_backlog[0].drain_first || rsp_due.size() == 0) begin
                  // a drain marker holds the beat until every response is back
                  item_n  = cmd_backlog[0].cmd;
                  start_n = 1'b1;
                  void'(cmd_backlog.pop_front());
               end
            end
         end
         start    <= start_n;
         req_item <= item_n;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: take each strobed response and check it against the oldest
   // prediction
   // -------------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, what, want_v, got_v);
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (rsp_due.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: response with nothing pending, expected none, actual 0x%0h",
                        $time, rsp_item);
         end else begin
            want = rsp_due.pop_front();
            rsp_checked++;
            if (rsp_item.found !== want.found)
               report_mismatch("found", want.found, rsp_item.found);
            if (rsp_item.data !== want.data)
               report_mismatch("data", want.data, rsp_item.data);
            if (rsp_item.status !== want.status)
               report_mismatch("status", want.status, rsp_item.status);
            if (rsp_item.dropped !== want.dropped)
               report_mismatch("dropped", want.dropped, rsp_item.dropped);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: abort when neither a command nor a response moves for too long
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles, %0d responses outstanding",
                  $time, STALL_LIMIT, rsp_due.size());
         $display("[three_stack_sort_engine] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus build, reset, and end of run
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int roll;
      int len;
      int fills_done;
      int next_drain_at;
      int directed_cnt;
      logic [1:0] tgt;

      fills_done = 0;

      // directed: empty stacks first, then small known contents
      queue_cmd(ACT_POP,       TUBE_ONE,   8'h00);
      queue_cmd(ACT_POP,       TUBE_TWO,   8'hFF);
      queue_cmd(ACT_POP,       TUBE_THREE, 8'h00);
      queue_cmd(ACT_POP,       TUBE_NONE,  8'hFF);
      queue_cmd(ACT_SEARCH,    TUBE_ONE,   8'h00);
      queue_cmd(ACT_TRANSFER,  TUBE_NONE,  8'hFF);
      queue_cmd(ACT_PARTITION, TUBE_TWO,   8'h00);
      queue_cmd(ACT_LOAD,      TUBE_NONE,  8'hFF);
      queue_cmd(ACT_LOAD,      TUBE_ONE,   8'h00);
      queue_cmd(ACT_LOAD,      TUBE_ONE,   8'hFF);
      queue_cmd(ACT_LOAD,      TUBE_ONE,   8'hFF);
      queue_cmd(ACT_LOAD,      TUBE_ONE,   8'h5A);
      queue_cmd(ACT_SEARCH,    TUBE_THREE, 8'hFF);
      queue_cmd(ACT_SEARCH,    TUBE_ONE,   8'hA5);
      queue_cmd(ACT_PARTITION, TUBE_ONE,   8'hFF);
      queue_cmd(ACT_POP,       TUBE_THREE, 8'h00);
      queue_cmd(ACT_POP,       TUBE_TWO,   8'h00);
      queue_cmd(ACT_LOAD,      TUBE_ONE,   8'h81);
      queue_cmd(ACT_LOAD,      TUBE_ONE,   8'h7E);
      queue_cmd(ACT_TRANSFER,  TUBE_ONE,   8'h00);
      queue_cmd(ACT_POP,       TUBE_TWO,   8'hFF);
      queue_cmd(ACT_SPARE_LO,  TUBE_NONE,  8'hFF);
      queue_cmd(3'd6,          TUBE_ONE,   8'h00);
      queue_cmd(ACT_SPARE_HI,  TUBE_TWO,   8'hAA);
      queue_cmd(ACT_POP,       TUBE_ONE,   8'h00);
      directed_cnt = cmd_backlog.size();

      // random: load bursts, walks and pop bursts over a shifting palette
      refresh_palette();
      useful_cnt    = 0;
      next_drain_at = 0;
      while (useful_cnt < RANDOM_ITEMS) begin
         if (useful_cnt >= next_drain_at) begin
            want_drain    = 1'b1;
            next_drain_at = next_drain_at + DRAIN_EVERY;
         end
         if ($urandom_range(7, 0) == 0) refresh_palette();
         roll = $urandom_range(99, 0);
         if (roll < 35) begin
            tgt = ($urandom_range(4, 0) < 3) ? TUBE_ONE : real_tube();
            len = $urandom_range(10, 1);
            repeat (len) queue_cmd(ACT_LOAD, tgt, pick_color());
         end else if (roll < 47) begin
            queue_cmd(ACT_SEARCH, any_tube(), pick_color());
         end else if (roll < 57) begin
            queue_cmd(ACT_PARTITION, any_tube(), pick_color());
         end else if (roll < 65) begin
            queue_cmd(ACT_TRANSFER, any_tube(), 8'($urandom_range(255, 0)));
         end else if (roll < 82) begin
            len = $urandom_range(6, 1);
            repeat (len) queue_cmd(ACT_POP, real_tube(), 8'($urandom_range(255, 0)));
         end else if (roll < 87) begin
            queue_cmd(3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO)), any_tube(),
                      8'($urandom_range(255, 0)));
         end else if (roll < 91 && fills_done < MAX_FILLS) begin
            // fill one tube past its depth, then force a walk from or into it
            fills_done++;
            tgt = 2'($urandom_range(2, 0));
            repeat (DEPTH + 2) queue_cmd(ACT_LOAD, tgt, pick_color());
            if (tgt == TUBE_ONE) begin
               queue_cmd(ACT_SEARCH, any_tube(), pick_color());
               queue_cmd(ACT_PARTITION, any_tube(), pick_color());
            end else begin
               len = $urandom_range(6, 2);
               repeat (len) queue_cmd(ACT_LOAD, TUBE_ONE, pick_color());
               if (tgt == TUBE_TWO && $urandom_range(1, 0) == 1)
                  queue_cmd(ACT_TRANSFER, any_tube(), pick_color());
               else
                  queue_cmd(ACT_PARTITION, any_tube(), pick_color());
            end
         end else begin
            queue_cmd(3'($urandom_range(7, 0)), any_tube(), 8'($urandom_range(255, 0)));
         end
      end

      // release reset once, then let the driver run the backlog dry
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (cmd_backlog.size() != 0 || start || rsp_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (rsp_due.size() != 0) begin
         errors += rsp_due.size();
         $display("%0t: %0d expected responses never arrived", $time, rsp_due.size());
      end

      $display("Covered %0d commands (%0d directed) with %0d responses checked;",
               cmds_taken, directed_cnt, rsp_checked);
      $display("%0d search hits, %0d empty pops, %0d overflow commands, deepest stack %0d/%0d.",
               search_hits, empty_pops, drop_cmds, peak_fill, DEPTH);
      if (errors == 0) begin
         $display("[three_stack_sort_engine] OK");
      end else begin
         $display("[three_stack_sort_engine] ERROR");
      end
      $finish;
   end

endmodule

// ===== three_stack_sort_engine.f =====
sv/tsse_pkg.sv
sv/tsse_ram.sv
sv/tsse_front.sv
sv/tsse_back.sv
sv/three_stack_sort_engine.sv
sv/tsse_checker.sv
sim/three_stack_sort_engine_tb.sv
